// File: design/rar_pkg.sv
// Package for the fraction arithmetic block: widths, operation codes, control structs.
// No dependencies.
`timescale 1ns / 1ps
package rar_pkg;
	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W = 2 * OPERAND_WIDTH;
	localparam int SUM_W = PROD_W + 1;
	localparam int NUM_W = 32;
	localparam int DEN_W = 31;
	localparam int CNT_W = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture operands
		logic mul;       // form products
		logic combine;   // form num/den
		logic gcd_step;  // one binary gcd step
		logic div_init;  // start both divisions
		logic div_step;  // one restoring division bit
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic bad;       // zero denominator or divisor
		logic num_zero;
		logic gcd_done;
		logic div_done;
	} dp_stat_t;
endpackage

// File: design/rar_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface rar_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/rar_datapath.sv
// Datapath: products, signed sum, binary gcd and bit-serial division.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_datapath (
	input  logic clk,
	input  rar_pkg::dp_cmd_t cmd,
	input  logic [1:0] op,
	input  logic [rar_pkg::OPERAND_WIDTH-1:0] a_num,
	input  logic [rar_pkg::OPERAND_WIDTH-1:0] a_den,
	input  logic [rar_pkg::OPERAND_WIDTH-1:0] b_num,
	input  logic [rar_pkg::OPERAND_WIDTH-1:0] b_den,
	output rar_pkg::dp_stat_t stat,
	output logic [rar_pkg::NUM_W-1:0] res_num,
	output logic [rar_pkg::DEN_W-1:0] res_den
);
	localparam int W = rar_pkg::OPERAND_WIDTH;
	localparam int P = rar_pkg::PROD_W;
	localparam int S = rar_pkg::SUM_W;
	localparam int R = (S > rar_pkg::NUM_W) ? S : rar_pkg::NUM_W;

	logic [1:0] op_q;
	logic [W-1:0] m_an_q, m_ad_q, m_bn_q, m_bd_q;
	logic s_an_q, s_ad_q, s_bn_q, s_bd_q;
	logic [P-1:0] p1_q, p2_q, p3_q;
	logic n1_q, n2_q, n3_q;
	logic [S-1:0] num_q, den_q;
	logic neg_q;
	logic [S-1:0] gx_q, gy_q;
	logic [$clog2(S+1)-1:0] sh_q;
	logic [S-1:0] qn_q, rn_q, qd_q, rd_q, g_q;
	logic [rar_pkg::CNT_W-1:0] bit_q;

	function automatic logic [W:0] to_sm(input logic [W-1:0] v);
		logic [W-1:0] m;
		m = v[W-1] ? (~v + 1'b1) : v;
		return {v[W-1], m};
	endfunction

	logic [W:0] an_sm, ad_sm, bn_sm, bd_sm;
	assign an_sm = to_sm(a_num);
	assign ad_sm = to_sm(a_den);
	assign bn_sm = to_sm(b_num);
	assign bd_sm = to_sm(b_den);

	assign stat.bad = (m_ad_q == '0) || (m_bd_q == '0) ||
		(op_q == rar_pkg::OP_DIV && m_bn_q == '0);
	assign stat.num_zero = (num_q == '0);
	assign stat.gcd_done = (gy_q == '0);
	assign stat.div_done = (bit_q == '0);

	// signed combination of the two cross products
	logic [S-1:0] x1, x2, sum_mag;
	logic sum_neg, sub_n2;
	always_comb begin
		x1 = {1'b0, p1_q};
		x2 = {1'b0, p2_q};
		sub_n2 = n2_q ^ (op_q == rar_pkg::OP_SUB);
		if (n1_q == sub_n2) begin
			sum_mag = x1 + x2;
			sum_neg = n1_q;
		end else if (x1 >= x2) begin
			sum_mag = x1 - x2;
			sum_neg = n1_q;
		end else begin
			sum_mag = x2 - x1;
			sum_neg = sub_n2;
		end
	end

	// binary gcd step: strip common twos, halve a lone even value, else subtract odd values
	logic [S-1:0] gdiff;
	assign gdiff = (gx_q > gy_q) ? (gx_q - gy_q) : (gy_q - gx_q);

	// restoring division bit step
	logic [S:0] tn, td;
	assign tn = {rn_q, qn_q[S-1]} - {1'b0, g_q};
	assign td = {rd_q, qd_q[S-1]} - {1'b0, g_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			{s_an_q, m_an_q} <= an_sm;
			{s_ad_q, m_ad_q} <= ad_sm;
			{s_bn_q, m_bn_q} <= bn_sm;
			{s_bd_q, m_bd_q} <= bd_sm;
		end
		if (cmd.mul) begin
			unique case (op_q)
				rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
					p1_q <= P'(m_an_q) * P'(m_bd_q); n1_q <= s_an_q ^ s_bd_q;
					p2_q <= P'(m_bn_q) * P'(m_ad_q); n2_q <= s_bn_q ^ s_ad_q;
					p3_q <= P'(m_ad_q) * P'(m_bd_q); n3_q <= s_ad_q ^ s_bd_q;
				end
				rar_pkg::OP_MUL: begin
					p1_q <= P'(m_an_q) * P'(m_bn_q); n1_q <= s_an_q ^ s_bn_q;
					p2_q <= '0; n2_q <= 1'b0;
					p3_q <= P'(m_ad_q) * P'(m_bd_q); n3_q <= s_ad_q ^ s_bd_q;
				end
				default: begin
					p1_q <= P'(m_an_q) * P'(m_bd_q); n1_q <= s_an_q ^ s_bd_q;
					p2_q <= '0; n2_q <= 1'b0;
					p3_q <= P'(m_ad_q) * P'(m_bn_q); n3_q <= s_ad_q ^ s_bn_q;
				end
			endcase
		end
		if (cmd.combine) begin
			num_q <= sum_mag;
			den_q <= {1'b0, p3_q};
			neg_q <= (sum_neg ^ n3_q);
			gx_q <= sum_mag;
			gy_q <= {1'b0, p3_q};
			sh_q <= '0;
		end
		if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; sh_q <= sh_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else begin
				gx_q <= (gx_q < gy_q) ? gx_q : gy_q;
				gy_q <= gdiff;
			end
		end
		if (cmd.div_init) begin
			g_q <= gx_q << sh_q;
			qn_q <= num_q; rn_q <= '0;
			qd_q <= den_q; rd_q <= '0;
			bit_q <= rar_pkg::CNT_W'(S);
		end
		if (cmd.div_step) begin
			bit_q <= bit_q - 1'b1;
			if (!tn[S]) begin
				rn_q <= tn[S-1:0]; qn_q <= {qn_q[S-2:0], 1'b1};
			end else begin
				rn_q <= {rn_q[S-2:0], qn_q[S-1]}; qn_q <= {qn_q[S-2:0], 1'b0};
			end
			if (!td[S]) begin
				rd_q <= td[S-1:0]; qd_q <= {qd_q[S-2:0], 1'b1};
			end else begin
				rd_q <= {rd_q[S-2:0], qd_q[S-1]}; qd_q <= {qd_q[S-2:0], 1'b0};
			end
		end
	end

	// quotients widened to at least the result fields before sign and truncation
	logic [R-1:0] qn_x, qd_x, qn_s;
	assign qn_x = R'(qn_q);
	assign qd_x = R'(qd_q);
	assign qn_s = neg_q ? (~qn_x + 1'b1) : qn_x;
	assign res_num = qn_s[rar_pkg::NUM_W-1:0];
	assign res_den = qd_x[rar_pkg::DEN_W-1:0];
endmodule

// File: design/rar_ctrl.sv
// Controller: sequences load, multiply, combine, gcd and division; holds the error and zero-result flags.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output rar_pkg::dp_cmd_t cmd,
	input  rar_pkg::dp_stat_t stat,
	output logic sel_bad,
	output logic sel_zero
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_GCD, S_DIV, S_OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.mul = (state_q == S_MUL);
		cmd.combine = (state_q == S_COMB);
		cmd.gcd_step = (state_q == S_GCD) && !stat.gcd_done;
		cmd.div_init = (state_q == S_GCD) && stat.gcd_done;
		cmd.div_step = (state_q == S_DIV) && !stat.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_bad <= 1'b0;
			sel_zero <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL;
				S_MUL: begin
					sel_bad <= stat.bad;
					sel_zero <= 1'b0;
					state_q <= stat.bad ? S_OUT : S_COMB;
				end
				S_COMB: state_q <= S_GCD;
				S_GCD: begin
					if (stat.num_zero) begin
						sel_zero <= 1'b1;
						state_q <= S_OUT;
					end else if (stat.gcd_done) state_q <= S_DIV;
				end
				S_DIV: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/rational_arith_reduce.sv
// Top level of fraction arithmetic with gcd reduction.
// Depends on rar_pkg, rar_if, rar_ctrl, rar_datapath.
//  channel  | direction | payload
//  in_ch    | sink      | operation, a_num, a_den, b_num, b_den
//  out_ch   | source    | result_num, result_den, error
// One item at a time: load, multiply and combine, then binary gcd steps with a
// finish step that starts both divisions, then two 33-bit restoring divisions
// bit-serially, then the output state. Error items go from multiply straight to
// output; zero numerator items go from the gcd state straight to output.
// arst_n clears the controller only; the result holds while out_ch stalls.
`timescale 1ns / 1ps
module rational_arith_reduce (
	input logic clk,
	input logic arst_n,
	rar_if.sink in_ch,
	rar_if.source out_ch
);
	rar_pkg::dp_cmd_t cmd;
	rar_pkg::dp_stat_t stat;
	logic sel_bad, sel_zero;
	logic [rar_pkg::NUM_W-1:0] rn;
	logic [rar_pkg::DEN_W-1:0] rd;

	rar_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .stat(stat), .sel_bad(sel_bad), .sel_zero(sel_zero)
	);

	rar_datapath u_dp (
		.clk(clk), .cmd(cmd), .op(in_ch.data.operation),
		.a_num(in_ch.data.a_num[rar_pkg::OPERAND_WIDTH-1:0]),
		.a_den(in_ch.data.a_den[rar_pkg::OPERAND_WIDTH-1:0]),
		.b_num(in_ch.data.b_num[rar_pkg::OPERAND_WIDTH-1:0]),
		.b_den(in_ch.data.b_den[rar_pkg::OPERAND_WIDTH-1:0]),
		.stat(stat), .res_num(rn), .res_den(rd)
	);

	// special results override the quotient
	always_comb begin
		out_ch.data.error = sel_bad;
		if (sel_bad) begin
			out_ch.data.result_num = '0;
			out_ch.data.result_den = '0;
		end else if (sel_zero) begin
			out_ch.data.result_num = '0;
			out_ch.data.result_den = rar_pkg::DEN_W'(1);
		end else begin
			out_ch.data.result_num = rn;
			out_ch.data.result_den = rd;
		end
	end
endmodule
